// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the windowed statistics block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every clock edge, suspended while reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check on every clock edge, reset included
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_NORST(lbl, clk, prop)

`endif

`endif

// ----- hw/rtl/wmms_pkg.sv -----
// Package for the windowed min/max/mean statistics block: sizes, types, codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package wmms_pkg;

  // Window and sample geometry
  localparam int unsigned WindowDepth = 64;
  localparam int unsigned SampleBits  = 48;
  localparam int unsigned NumChan     = 3;
  localparam int unsigned SlotW       = $clog2(WindowDepth);
  localparam int unsigned CntW        = $clog2(WindowDepth + 1);
  localparam int unsigned SumW        = SampleBits + $clog2(WindowDepth);

  // Register and field widths
  localparam int unsigned SizeW     = 7;
  localparam int unsigned IntervalW = 32;
  localparam int unsigned StepBits  = 20;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [SizeW-1:0]     SizeReset     = 7'd64;
  localparam logic [IntervalW-1:0] IntervalReset = 32'd65536;

  // Command queue between front and back
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowSize     = 1'b0,
    CfgReportInterval = 1'b1
  } cfg_reg_e;

  typedef logic [SampleBits-1:0] sample_t;
  typedef sample_t [NumChan-1:0] samples_t;

  // One classified item: samples to store, and the scan range if a report is due
  typedef struct packed {
    samples_t               samples;
    logic [SlotW-1:0]       slot;
    logic                   report;
    logic [CntW-1:0]        count;
    logic [SlotW-1:0]       first;
  } cmd_t;

  typedef struct packed {
    sample_t mean;
    sample_t peak;
    sample_t least;
  } stat_t;

  typedef stat_t [NumChan-1:0] result_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkScan,
    BkDiv,
    BkDone
  } back_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/wmms_front.sv -----
// Front end: config registers, window bookkeeping and report timer.
// Depends on wmms_pkg; feeds classified items into the command queue.
`default_nettype none

module wmms_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wmms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [wmms_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         accept_i,
  input  wire wmms_pkg::samples_t           samples_i,
  input  wire logic [wmms_pkg::StepBits-1:0] time_step_i,
  output wmms_pkg::cmd_t                    cmd_o
);
  import wmms_pkg::*;

  logic [SizeW-1:0]     size_q;
  logic [IntervalW-1:0] interval_q;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [IntervalW-1:0] elapsed_q, elapsed_d;

  logic [CntW-1:0]      eff_size;
  logic [CntW:0]        fill_inc;
  logic [CntW:0]        slot_ext;
  logic [IntervalW:0]   time_sum;
  logic [IntervalW-1:0] time_sat;
  logic                 report;

  // Effective window size: zero acts as one, large values clamp to the depth
  always_comb begin
    if (size_q == '0) begin
      eff_size = CntW'(1);
    end else if (32'(size_q) > WindowDepth) begin
      eff_size = CntW'(WindowDepth);
    end else begin
      eff_size = CntW'(size_q);
    end
  end

  // Next fill level and write slot
  always_comb begin
    fill_inc = {1'b0, fill_q} + (CntW+1)'(1);
    fill_d   = (fill_inc > {1'b0, eff_size}) ? eff_size : CntW'(fill_inc);
    slot_d   = (slot_q == SlotW'(WindowDepth - 1)) ? '0 : slot_q + SlotW'(1);
  end

  // Saturating timer and report decision
  always_comb begin
    time_sum  = {1'b0, elapsed_q} + (IntervalW+1)'(time_step_i);
    time_sat  = time_sum[IntervalW] ? '1 : time_sum[IntervalW-1:0];
    report    = time_sat > interval_q;
    elapsed_d = report ? '0 : time_sat;
  end

  // Classified item; oldest slot of the window after this write
  always_comb begin
    slot_ext       = (CntW+1)'(slot_d);
    cmd_o.samples  = samples_i;
    cmd_o.slot     = slot_q;
    cmd_o.report   = report;
    cmd_o.count    = fill_d;
    if (slot_ext >= {1'b0, fill_d}) begin
      cmd_o.first = SlotW'(slot_ext - {1'b0, fill_d});
    end else begin
      cmd_o.first = SlotW'(slot_ext + (CntW+1)'(WindowDepth) - {1'b0, fill_d});
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= SizeReset;
      interval_q <= IntervalReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgWindowSize:     size_q     <= cfg_data_i[SizeW-1:0];
        CfgReportInterval: interval_q <= cfg_data_i[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // Window bookkeeping and timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      slot_q    <= '0;
      elapsed_q <= '0;
    end else if (accept_i) begin
      fill_q    <= fill_d;
      slot_q    <= slot_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wmms_fifo.sv -----
// Short command queue between the front end and the scan engine.
// Depends on wmms_pkg for the command type and queue depth.
`default_nettype none

module wmms_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wmms_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output wmms_pkg::cmd_t      data_o,
  output logic                empty_o
);
  import wmms_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + CmdPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + CmdPtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CmdCntW'(1);
        2'b01:   cnt_q <= cnt_q - CmdCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wmms_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle: window sum / count.
// Depends on wmms_pkg for sum, count and sample widths.
`default_nettype none

module wmms_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [wmms_pkg::SumW-1:0] dividend_i,
  input  wire logic [wmms_pkg::CntW-1:0] divisor_i,
  output logic                           done_o,
  output wmms_pkg::sample_t              quotient_o
);
  import wmms_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  dvd_q;
  logic [CntW-1:0]  rem_q, dsr_q;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q;

  logic [CntW:0]    shifted;
  logic             ge;
  logic [CntW:0]    diff;

  // One step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, dvd_q[SumW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q[SampleBits-1:0];

  // Datapath; quotient bits enter at the bottom of the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SumW-2:0], ge};
      rem_q <= ge ? diff[CntW-1:0] : shifted[CntW-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(SumW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wmms_back.sv -----
// Back end: sample window memory, scan for sum/min/max, three dividers.
// Depends on wmms_pkg, wmms_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wmms_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire wmms_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                res_valid_o,
  output wmms_pkg::result_t   res_o,
  input  wire logic           res_ready_i
);
  import wmms_pkg::*;

  back_state_e state_q, state_d;

  samples_t                     win_mem [WindowDepth];
  samples_t                     rd_data_q;
  logic [SlotW-1:0]             rd_addr_q;
  logic [CntW-1:0]              rd_cnt_q, cnt_q;
  logic                         rd_vld_q;
  logic [NumChan-1:0][SumW-1:0] sum_q;
  samples_t                     max_q, min_q;

  logic                         mem_we;
  logic                         scan_init;
  logic                         issue;
  logic                         div_start;
  logic [NumChan-1:0]           div_done;
  samples_t                     quotient;

  assign issue = (state_q == BkScan) && (rd_cnt_q < cnt_q);

  // Sequencer: store, scan, divide, hand off
  always_comb begin
    state_d     = state_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    scan_init   = 1'b0;
    div_start   = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      BkIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          mem_we    = 1'b1;
          if (cmd_i.report) begin
            scan_init = 1'b1;
            state_d   = BkScan;
          end
        end
      end
      BkScan: begin
        if (!issue && !rd_vld_q) begin
          div_start = 1'b1;
          state_d   = BkDiv;
        end
      end
      BkDiv: begin
        if (div_done[0]) begin
          state_d = BkDone;
        end
      end
      BkDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[cmd_i.slot] <= cmd_i.samples;
    end
    rd_data_q <= win_mem[rd_addr_q];
  end

  // Scan address generation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_cnt_q <= '0;
      cnt_q    <= '0;
      rd_addr_q <= '0;
    end else begin
      rd_vld_q <= issue;
      if (scan_init) begin
        rd_cnt_q  <= '0;
        cnt_q     <= cmd_i.count;
        rd_addr_q <= cmd_i.first;
      end else if (issue) begin
        rd_cnt_q  <= rd_cnt_q + CntW'(1);
        rd_addr_q <= (rd_addr_q == SlotW'(WindowDepth - 1)) ? '0 : rd_addr_q + SlotW'(1);
      end
    end
  end

  // Running sum, maximum and minimum per channel
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumChan; c++) begin
      if (scan_init) begin
        sum_q[c] <= '0;
        max_q[c] <= '0;
        min_q[c] <= '1;
      end else if (rd_vld_q) begin
        sum_q[c] <= sum_q[c] + SumW'(rd_data_q[c]);
        if (rd_data_q[c] > max_q[c]) max_q[c] <= rd_data_q[c];
        if (rd_data_q[c] < min_q[c]) min_q[c] <= rd_data_q[c];
      end
    end
  end

  // Mean per channel
  for (genvar c = 0; c < NumChan; c++) begin : g_div
    wmms_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (sum_q[c]),
      .divisor_i  (cnt_q),
      .done_o     (div_done[c]),
      .quotient_o (quotient[c])
    );
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      res_o[c].mean  = quotient[c];
      res_o[c].peak  = max_q[c];
      res_o[c].least = min_q[c];
    end
  end

  // Checks
  `ASSERT_RST(divAligned_a, clk_i, rst_ni, (div_done[0] == div_done[1]) && (div_done[1] == div_done[2]))
  `ASSERT_RST(scanBound_a, clk_i, rst_ni, (state_q == BkScan) |-> (rd_cnt_q <= cnt_q))
  `ASSERT_RST(scanNonEmpty_a, clk_i, rst_ni, (state_q == BkScan) |-> (cnt_q != '0))
  `ASSERT_RST(peakAboveLeast_a, clk_i, rst_ni, (state_q == BkDiv && $past(state_q) == BkScan) |-> (max_q[0] >= min_q[0]))

endmodule

`default_nettype wire

// ----- hw/rtl/windowed_min_max_mean_stats.sv -----
// Top level of the windowed min/max/mean statistics block.
// Depends on wmms_pkg, wmms_front, wmms_fifo, wmms_back.
//
// Usage:
//   Input queue: drive the three usage samples and time_step_i, raise push;
//   the item is taken on a clock edge with push high and full low.
//   Result queue: while empty is low the ports carry the oldest report; it is
//   taken on a clock edge with pop high and empty low.
//   Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 window size,
//   1 report interval) at the clock edge; write only while the block is idle.
// Processing:
//   An item that raises no report is just stored in the window memory. A report
//   for a window of N entries passes two phases from accept to result:
//   one memory read per entry for the scan, then 54 divider steps for the mean.
//   Items queue in a two-entry command queue meanwhile; full rises when it fills.
// Reset:
//   rst_ni clears counters, timer and queues and loads register defaults
//   (window 64, interval 1.0 s). No clearing pass is needed.
// Stall:
//   A held result blocks the scan engine only after the next report is done;
//   input items keep queuing until the command queue is full.
`default_nettype none

module windowed_min_max_mean_stats (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wmms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wmms_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire wmms_pkg::sample_t             ram_used_i,
  input  wire wmms_pkg::sample_t             vram_used_i,
  input  wire wmms_pkg::sample_t             gpu_used_i,
  input  wire logic [wmms_pkg::StepBits-1:0] time_step_i,
  output logic                               empty,
  input  wire logic                          pop,
  output wmms_pkg::sample_t                  ram_mean_o,
  output wmms_pkg::sample_t                  ram_peak_o,
  output wmms_pkg::sample_t                  ram_least_o,
  output wmms_pkg::sample_t                  vram_mean_o,
  output wmms_pkg::sample_t                  vram_peak_o,
  output wmms_pkg::sample_t                  vram_least_o,
  output wmms_pkg::sample_t                  gpu_mean_o,
  output wmms_pkg::sample_t                  gpu_peak_o,
  output wmms_pkg::sample_t                  gpu_least_o
);
  import wmms_pkg::*;

  samples_t samples;
  cmd_t     front_cmd, back_cmd;
  logic     accept;
  logic     cmd_empty, cmd_pop;
  logic     res_valid, res_ready;
  result_t  res, out_q;
  logic     out_vld_q;

  assign samples[0] = ram_used_i;
  assign samples[1] = vram_used_i;
  assign samples[2] = gpu_used_i;
  assign accept     = push && !full;

  wmms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .samples_i   (samples),
    .time_step_i (time_step_i),
    .cmd_o       (front_cmd)
  );

  wmms_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  wmms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register; refills in the cycle the held item is popped
  assign res_ready = !out_vld_q || pop;
  assign empty     = !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign ram_mean_o   = out_q[0].mean;
  assign ram_peak_o   = out_q[0].peak;
  assign ram_least_o  = out_q[0].least;
  assign vram_mean_o  = out_q[1].mean;
  assign vram_peak_o  = out_q[1].peak;
  assign vram_least_o = out_q[1].least;
  assign gpu_mean_o   = out_q[2].mean;
  assign gpu_peak_o   = out_q[2].peak;
  assign gpu_least_o  = out_q[2].least;

endmodule

`default_nettype wire
